// File: rtl/tpl_pkg.sv
// ----------------------------------------------------------------------------
// tpl_pkg
// Types and constants shared by the torus packet latency estimator.
// ----------------------------------------------------------------------------
package tpl_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_ENABLED    = 3'd0,
    CFG_RADIX      = 3'd1,
    CFG_DIMENSIONS = 3'd2,
    CFG_CHAN_WIDTH = 3'd3,
    CFG_HOP_COST   = 3'd4,
    CFG_CONT_SCALE = 3'd5
  } cfg_idx_e;

  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned FNUM_W     = 20;   // len*8 + width - 1
  localparam int unsigned W_W        = 52;   // contention term, Q.16
  localparam logic [39:0] MAX40      = 40'hFF_FFFF_FFFF;

  typedef struct packed {
    logic        enabled;
    logic [8:0]  radix;
    logic [2:0]  dimensions;
    logic [8:0]  channel_width;
    logic [31:0] hop_cost;
    logic [15:0] contention_scale;
  } cfg_t;

  typedef struct packed {
    logic [15:0] src_node;
    logic [15:0] dst_node;
    logic [15:0] length_bytes;
    logic [15:0] utilization;
  } in_t;

  typedef struct packed {
    logic [39:0] latency_cycles;
    logic [39:0] contention_cycles;
    logic [31:0] flit_hops;
  } out_t;

  // Classified packet as held between front and back
  typedef struct packed {
    logic              zero;
    logic [15:0]       src;
    logic [15:0]       dst;
    logic [FNUM_W-1:0] fnum;
    logic [8:0]        fden;
    logic [31:0]       pnum;
    logic [16:0]       pden;
  } qent_t;

endpackage

// File: rtl/tpl_front.sv
// ----------------------------------------------------------------------------
// tpl_front
// Accepts a packet, flags self-sends and disabled mode, and prepares the
// dividends and divisors for the flit count and the contention ratio.
// ----------------------------------------------------------------------------
module tpl_front import tpl_pkg::*; #(
  parameter int unsigned NODE_BITS = 16
) (
  input  cfg_t  cfg_i,
  input  logic  start_i,
  input  logic  full_i,
  input  in_t   req_i,
  output logic  push_o,
  output qent_t ent_o
);

  localparam logic [15:0] NODE_MASK =
    (NODE_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << NODE_BITS) - 32'd1);

  logic [15:0] src, dst;
  logic [8:0]  width;

  // Transfer when the queue has room
  assign push_o = start_i && !full_i;

  // Classify and prepare operands
  always_comb begin
    src          = req_i.src_node & NODE_MASK;
    dst          = req_i.dst_node & NODE_MASK;
    width        = (cfg_i.channel_width == 9'd0) ? 9'd1 : cfg_i.channel_width;
    ent_o.zero   = !cfg_i.enabled || (src == dst);
    ent_o.src    = src;
    ent_o.dst    = dst;
    ent_o.fden   = width;
    ent_o.fnum   = {1'b0, req_i.length_bytes, 3'b000} + FNUM_W'(width) - FNUM_W'(1);
    ent_o.pnum   = 32'(req_i.utilization) * 32'(cfg_i.contention_scale);
    ent_o.pden   = 17'h1_0000 - {1'b0, req_i.utilization};
  end

endmodule

// File: rtl/tpl_queue.sv
// ----------------------------------------------------------------------------
// tpl_queue
// Two-entry queue between the front and the back.
// ----------------------------------------------------------------------------
module tpl_queue import tpl_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  qent_t ent_i,
  input  logic  pop_i,
  output logic  full_o,
  output logic  empty_o,
  output qent_t head_o
);

  qent_t      mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign head_o  = mem_q[rp_q];
  assign do_pop  = pop_i && !empty_o;

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= !wp_q;
      if (do_pop) rp_q <= !rp_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(do_pop);
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= ent_i;
  end

endmodule

// File: rtl/tpl_div.sv
// ----------------------------------------------------------------------------
// tpl_div
// Pipelined restoring divider, one quotient bit per stage, with a side word
// that travels alongside the operands.
// ----------------------------------------------------------------------------
module tpl_div #(
  parameter int unsigned NW = 16,
  parameter int unsigned DW = 9,
  parameter int unsigned SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic [NW-1:0] quot_o,
  output logic [DW-1:0] rem_o,
  output logic [SW-1:0] side_o
);

  logic [NW-1:0] nq_q   [NW];
  logic [DW-1:0] rem_q  [NW];
  logic [DW-1:0] den_q  [NW];
  logic [SW-1:0] side_q [NW];

  for (genvar s = 0; s < NW; s++) begin : g_stage
    logic [NW-1:0] nq_in;
    logic [DW-1:0] rem_in, den_in;
    logic [SW-1:0] side_in;
    logic [DW:0]   trial, diffv;
    logic          qbit;

    if (s == 0) begin : g_first
      assign nq_in   = num_i;
      assign rem_in  = '0;
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_next
      assign nq_in   = nq_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign den_in  = den_q[s-1];
      assign side_in = side_q[s-1];
    end

    // Trial subtract of the shifted partial remainder
    always_comb begin
      trial = {rem_in, nq_in[NW-1]};
      diffv = trial - {1'b0, den_in};
      qbit  = (trial >= {1'b0, den_in});
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        nq_q[s]   <= '0;
        rem_q[s]  <= '0;
        den_q[s]  <= '0;
        side_q[s] <= '0;
      end else begin
        nq_q[s]   <= {nq_in[NW-2:0], qbit};
        rem_q[s]  <= qbit ? diffv[DW-1:0] : trial[DW-1:0];
        den_q[s]  <= den_in;
        side_q[s] <= side_in;
      end
    end
  end

  assign quot_o = nq_q[NW-1];
  assign rem_o  = rem_q[NW-1];
  assign side_o = side_q[NW-1];

endmodule

// File: rtl/tpl_back.sv
// ----------------------------------------------------------------------------
// tpl_back
// Execution pipeline: digit-by-digit hop distance, flit and contention
// division, then the products and saturation of the three results.
// ----------------------------------------------------------------------------
module tpl_back import tpl_pkg::*; #(
  parameter int unsigned MAX_DIMS  = 4,
  parameter int unsigned NODE_BITS = 16
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  input  logic  empty_i,
  input  qent_t head_i,
  output logic  pop_o,
  output logic  done_o,
  output out_t  res_o
);

  localparam int unsigned NB     = (NODE_BITS > 16) ? 16 : NODE_BITS;
  localparam int unsigned DIST_W = $clog2(MAX_DIMS * 510 + 1);
  localparam int unsigned FS_W   = ((DIST_W > FNUM_W) ? DIST_W : FNUM_W) + 1;
  localparam int unsigned FH_W   = FNUM_W + FS_W;
  localparam int unsigned DWW    = DIST_W + W_W;
  localparam int unsigned HW     = DWW + 1;
  localparam int unsigned NCH    = (HW + 31) / 32;
  localparam int unsigned PW     = (NCH + 1) * 32;

  typedef struct packed {
    logic              vld;
    logic [FNUM_W-1:0] fnum;
    logic [8:0]        fden;
    logic [31:0]       pnum;
    logic [16:0]       pden;
    logic [DIST_W-1:0] hop_dist;
  } dside_t;

  typedef struct packed {
    logic              vld;
    logic [DIST_W-1:0] hop_dist;
  } pside_t;

  // Drain the queue every cycle
  assign pop_o = !empty_i;

  dside_t s0_side;
  always_comb begin
    s0_side.vld      = !empty_i;
    s0_side.fnum     = head_i.fnum;
    s0_side.fden     = head_i.fden;
    s0_side.pnum     = head_i.pnum;
    s0_side.pden     = head_i.pden;
    s0_side.hop_dist = '0;
  end

  // Digit stages
  logic [NB-1:0] dg_src_q  [MAX_DIMS];
  logic [NB-1:0] dg_dst_q  [MAX_DIMS];
  dside_t        dg_side_q [MAX_DIMS];
  logic          dg_zero_q [MAX_DIMS];

  for (genvar i = 0; i < MAX_DIMS; i++) begin : g_digit
    logic [NB-1:0] src_in, dst_in, sq, dq;
    dside_t        side_in, side_out, side_nxt;
    logic          zero_in, zero_out;
    logic [8:0]    rs, rd, diff;
    logic          active;

    if (i == 0) begin : g_first
      assign src_in  = head_i.src[NB-1:0];
      assign dst_in  = head_i.dst[NB-1:0];
      assign side_in = s0_side;
      assign zero_in = head_i.zero;
    end else begin : g_next
      assign src_in  = dg_src_q[i-1];
      assign dst_in  = dg_dst_q[i-1];
      assign side_in = dg_side_q[i-1];
      assign zero_in = dg_zero_q[i-1];
    end

    tpl_div #(.NW(NB), .DW(9), .SW($bits(dside_t))) u_src (
      .clk_i, .rst_ni, .num_i(src_in), .den_i(cfg_i.radix), .side_i(side_in),
      .quot_o(sq), .rem_o(rs), .side_o(side_out)
    );

    tpl_div #(.NW(NB), .DW(9), .SW(1)) u_dst (
      .clk_i, .rst_ni, .num_i(dst_in), .den_i(cfg_i.radix), .side_i(zero_in),
      .quot_o(dq), .rem_o(rd), .side_o(zero_out)
    );

    // Forward distance modulo radix
    always_comb begin
      diff     = (rs > rd) ? (cfg_i.radix - (rs - rd)) : (rd - rs);
      active   = (cfg_i.radix >= 9'd2) && (4'(i) < {1'b0, cfg_i.dimensions});
      side_nxt = side_out;
      side_nxt.hop_dist = side_out.hop_dist + (active ? DIST_W'(diff) : DIST_W'(0));
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dg_side_q[i] <= '0;
        dg_zero_q[i] <= 1'b0;
      end else begin
        dg_side_q[i] <= side_nxt;
        dg_zero_q[i] <= zero_out;
      end
    end

    always_ff @(posedge clk_i) begin
      dg_src_q[i] <= sq;
      dg_dst_q[i] <= dq;
    end
  end

  // Contention ratio and flit count
  dside_t      dfin;
  pside_t      ps_side_in, ps_side;
  logic [31:0] ps, fl_full;
  logic [16:0] ps_rem, fl_rem;
  logic        fl_zero;

  assign dfin                = dg_side_q[MAX_DIMS-1];
  assign ps_side_in.vld      = dfin.vld;
  assign ps_side_in.hop_dist = dfin.hop_dist;

  tpl_div #(.NW(32), .DW(17), .SW($bits(pside_t))) u_ps (
    .clk_i, .rst_ni, .num_i(dfin.pnum), .den_i(dfin.pden), .side_i(ps_side_in),
    .quot_o(ps), .rem_o(ps_rem), .side_o(ps_side)
  );

  tpl_div #(.NW(32), .DW(17), .SW(1)) u_fl (
    .clk_i, .rst_ni, .num_i({12'b0, dfin.fnum}), .den_i({8'b0, dfin.fden}),
    .side_i(dg_zero_q[MAX_DIMS-1]), .quot_o(fl_full), .rem_o(fl_rem), .side_o(fl_zero)
  );

  // Stage A: contention term and flit sum
  logic              a_vld_q, a_zero_q;
  logic [W_W-1:0]    a_w_q;
  logic [FS_W-1:0]   a_fsum_q;
  logic [FNUM_W-1:0] a_fl_q;
  logic [DIST_W-1:0] a_dist_q;
  // Stage B: products
  logic              b_vld_q, b_zero_q;
  logic [DWW-1:0]    b_dw_q;
  logic [FH_W-1:0]   b_fh_q;
  logic [FNUM_W-1:0] b_fl_q;
  logic [DIST_W-1:0] b_dist_q;
  // Stage C: hops sum
  logic              c_vld_q, c_zero_q;
  logic [HW-1:0]     c_hops_q;
  logic [DWW-1:0]    c_dw_q;
  logic [31:0]       c_fh_q;
  // Stage D: partial products with the hop cost
  logic              d_vld_q, d_zero_q;
  logic [63:0]       d_pph_q [NCH];
  logic [63:0]       d_ppc_q [NCH];
  logic [31:0]       d_fh_q;
  // Stage E: result
  logic              e_vld_q;
  out_t              e_res_q;

  logic [NCH*32-1:0] hp, dp;
  logic [PW-1:0]     ph, pc;
  logic [NCH*32-1:0] qh, qc;
  logic [39:0]       lat_d, con_d;

  always_comb begin
    hp = (NCH*32)'(c_hops_q);
    dp = (NCH*32)'(c_dw_q);
    ph = '0;
    pc = '0;
    for (int j = 0; j < NCH; j++) begin
      ph = ph + (PW'(d_pph_q[j]) << (32 * j));
      pc = pc + (PW'(d_ppc_q[j]) << (32 * j));
    end
    qh = ph[PW-1:32];
    qc = pc[PW-1:32];
    // Saturate at the 40-bit maximum, round latency up
    if (qh >= (NCH*32)'(MAX40)) lat_d = MAX40;
    else                        lat_d = qh[39:0] + 40'(ph[31:0] != 32'd0);
    if (qc >= (NCH*32)'(MAX40)) con_d = MAX40;
    else                        con_d = qc[39:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      d_vld_q <= 1'b0;
      e_vld_q <= 1'b0;
    end else begin
      a_vld_q <= ps_side.vld;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
      d_vld_q <= c_vld_q;
      e_vld_q <= d_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_zero_q <= fl_zero;
    a_w_q    <= W_W'(ps) * W_W'(fl_full[FNUM_W-1:0]);
    a_fsum_q <= FS_W'(ps_side.hop_dist) + FS_W'(fl_full[FNUM_W-1:0]);
    a_fl_q   <= fl_full[FNUM_W-1:0];
    a_dist_q <= ps_side.hop_dist;

    b_zero_q <= a_zero_q;
    b_dw_q   <= DWW'(a_dist_q) * DWW'(a_w_q);
    b_fh_q   <= FH_W'(a_fl_q) * FH_W'(a_fsum_q);
    b_fl_q   <= a_fl_q;
    b_dist_q <= a_dist_q;

    c_zero_q <= b_zero_q;
    c_hops_q <= HW'(b_dw_q) + (HW'(b_dist_q) << 16) + (HW'(b_fl_q) << 16);
    c_dw_q   <= b_dw_q;
    c_fh_q   <= (|b_fh_q[FH_W-1:32]) ? 32'hFFFF_FFFF : b_fh_q[31:0];

    d_zero_q <= c_zero_q;
    d_fh_q   <= c_fh_q;
    for (int j = 0; j < NCH; j++) begin
      d_pph_q[j] <= 64'(cfg_i.hop_cost) * 64'(hp[32*j +: 32]);
      d_ppc_q[j] <= 64'(cfg_i.hop_cost) * 64'(dp[32*j +: 32]);
    end

    if (d_zero_q) begin
      e_res_q <= '0;
    end else begin
      e_res_q.latency_cycles    <= lat_d;
      e_res_q.contention_cycles <= con_d;
      e_res_q.flit_hops         <= d_fh_q;
    end
  end

  assign done_o = e_vld_q;
  assign res_o  = e_res_q;

endmodule

// File: rtl/torus_packet_latency_estimator.sv
// ----------------------------------------------------------------------------
// torus_packet_latency_estimator
// Latency estimate for packets on a unidirectional k-ary n-cube torus.
//
//   channel  | handshake            | payload
//   ---------+----------------------+---------------------------
//   request  | start_i / busy_o     | req_i  (in_t)
//   result   | done_o strobe        | res_o  (out_t)
//   config   | cfg_we_i             | cfg_idx_i, cfg_wdata_i
//
// One packet may be taken every cycle. done_o pulses for one cycle, after
// the packet has passed the front queue, the digit dividers (NB stages plus
// one register each, NB = min(NODE_BITS,16)), the 32-stage ratio divider
// and five product stages.
// Reset restores the default registers and empties the pipeline.
// The receiver cannot stall; busy_o only reflects a full front queue.
// ----------------------------------------------------------------------------
module torus_packet_latency_estimator import tpl_pkg::*; #(
  parameter int unsigned MAX_DIMS  = 4,
  parameter int unsigned NODE_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  in_t                   req_i,
  input  logic                  cfg_we_i,
  input  logic [2:0]            cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output logic                  done_o,
  output out_t                  res_o
);

  cfg_t  cfg_q;
  qent_t ent, head;
  logic  push, pop, full, empty;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enabled          <= 1'b1;
      cfg_q.radix            <= 9'd4;
      cfg_q.dimensions       <= 3'd2;
      cfg_q.channel_width    <= 9'd32;
      cfg_q.hop_cost         <= 32'd131072;
      cfg_q.contention_scale <= 16'd8192;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_ENABLED:    cfg_q.enabled          <= cfg_wdata_i[0];
        CFG_RADIX:      cfg_q.radix            <= cfg_wdata_i[8:0];
        CFG_DIMENSIONS: cfg_q.dimensions       <= cfg_wdata_i[2:0];
        CFG_CHAN_WIDTH: cfg_q.channel_width    <= cfg_wdata_i[8:0];
        CFG_HOP_COST:   cfg_q.hop_cost         <= cfg_wdata_i;
        CFG_CONT_SCALE: cfg_q.contention_scale <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  assign busy_o = full;

  tpl_front #(.NODE_BITS(NODE_BITS)) u_front (
    .cfg_i(cfg_q), .start_i, .full_i(full), .req_i, .push_o(push), .ent_o(ent)
  );

  tpl_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .ent_i(ent), .pop_i(pop),
    .full_o(full), .empty_o(empty), .head_o(head)
  );

  tpl_back #(.MAX_DIMS(MAX_DIMS), .NODE_BITS(NODE_BITS)) u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .empty_i(empty), .head_i(head),
    .pop_o(pop), .done_o, .res_o
  );

endmodule

// File: rtl/tpl_checker.sv
// ----------------------------------------------------------------------------
// tpl_checker
// Port-level checks for the latency estimator, bound to the top level.
// ----------------------------------------------------------------------------
module tpl_checker import tpl_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic busy_o,
  input logic done_o,
  input out_t res_o
);

  // The back drains every cycle, so the front queue never fills
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_o)
    else $error("front queue filled up");

  // Contention is part of the latency
  a_lat_ge_con: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (res_o.latency_cycles >= res_o.contention_cycles))
    else $error("contention exceeds latency");

  // No result strobe while held in reset
  a_rst_quiet: assert property (@(posedge clk_i) !rst_ni |-> !done_o)
    else $error("result during reset");

  // A result never repeats into the cycle after reset release
  a_rel_quiet: assert property (@(posedge clk_i) $rose(rst_ni) |-> !done_o)
    else $error("result right after reset");

endmodule

bind torus_packet_latency_estimator tpl_checker u_tpl_checker (.*);
